>>> design/day_count_to_calendar_date_macros.svh
// ----------------------------------------------------------------------------
// day count to calendar date - assertion macros
// concurrent checks clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef DAY_COUNT_TO_CALENDAR_DATE_MACROS_SVH
`define DAY_COUNT_TO_CALENDAR_DATE_MACROS_SVH

// consequent in the same cycle
`define DCCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define DCCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/dccd_pkg.sv
// ----------------------------------------------------------------------------
// dccd_pkg
// types and constants shared by the day count to calendar date block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dccd_pkg;

	localparam int DAY_BITS_DEF = 20;
	localparam int DAY_W        = 20;
	localparam int YEAR_W       = 13;
	localparam int MONTH_W      = 4;
	localparam int MDAY_W       = 5;
	localparam int WDAY_W       = 3;
	localparam int YOFF_W       = 9;
	localparam int CYCLE_BITS   = 18;

	localparam int BASE_YEAR   = 2000;
	localparam int CYCLE_DAYS  = 146097;
	localparam int CYCLE_YEARS = 400;
	localparam int DAYS_LEAP   = 366;
	localparam int DAYS_COMMON = 365;
	localparam int WEEK_DAYS   = 7;

	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CYCLE,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              idle;
		logic [WDAY_W-1:0] residue;
	} wk_stat_t;

	// month length, february chosen by the leap flag
	function automatic logic [MDAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [MDAY_W-1:0] len;
		unique case (m)
			4'd0:    len = 5'd31;
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			4'd11:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// leap rule on the year offset within the 400-year cycle
	function automatic logic leap_off(input logic [YOFF_W-1:0] yoff);
		return (yoff[1:0] == 2'd0) && (yoff != 9'd100) && (yoff != 9'd200)
			&& (yoff != 9'd300);
	endfunction

endpackage

`default_nettype wire

>>> design/dccd_sub.sv
// ----------------------------------------------------------------------------
// dccd_sub
// shared compare and subtract unit for cycles, years and months
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dccd_sub #(
	parameter int W = 18
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic              ge,
	output logic [W-1:0]      diff
);

	logic [W:0] wide;

	assign wide = {1'b0, a} - {1'b0, b};
	assign ge   = ~wide[W];
	assign diff = wide[W-1:0];

endmodule

`default_nettype wire

>>> design/dccd_wkday.sv
// ----------------------------------------------------------------------------
// dccd_wkday
// residue modulo 7 from the sum of octal digits, as 8 is 1 modulo 7
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dccd_wkday #(
	parameter int NBITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire logic [NBITS-1:0]     value,
	output dccd_pkg::wk_stat_t        stat
);

	localparam int Groups = (NBITS + 2) / 3;
	localparam int PadW   = Groups * 3;
	// up to seven octal digits of at most 7 each stay below 64
	localparam int SumW   = 6;

	logic [PadW-1:0]                  padded;
	logic [SumW-1:0]                  digit_sum;
	logic [SumW-1:0]                  sum_q;
	logic                             pend_q;
	logic [3:0]                       fold1;
	logic [dccd_pkg::WDAY_W-1:0]      fold2;
	logic [dccd_pkg::WDAY_W-1:0]      res_d;
	logic [dccd_pkg::WDAY_W-1:0]      res_q;

	assign padded = PadW'(value);

	always_comb begin
		digit_sum = '0;
		for (int g = 0; g < Groups; g++) begin
			digit_sum = digit_sum + SumW'(padded[3*g +: 3]);
		end
	end

	assign fold1 = {1'b0, sum_q[5:3]} + {1'b0, sum_q[2:0]};
	assign fold2 = dccd_pkg::WDAY_W'(fold1[3]) + fold1[2:0];
	assign res_d = (fold2 == dccd_pkg::WDAY_W'(dccd_pkg::WEEK_DAYS)) ? '0 : fold2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum_q <= digit_sum;
		end
		if (pend_q) begin
			res_q <= res_d;
		end
	end

	assign stat.idle    = !pend_q;
	assign stat.residue = res_q;

endmodule

`default_nettype wire

>>> design/day_count_to_calendar_date.sv
// ----------------------------------------------------------------------------
// day_count_to_calendar_date
// converts days since 2000-01-01 to gregorian year, month, day and weekday
//
// channel   direction  transfer           payload
// command   in         start && !busy     day_offset
// result    out        done (one cycle)   year, month_number, day_of_month, weekday
//
// after a command transfer the block steps through ST_CYCLE, ST_YEAR, ST_MONTH and
// ST_DONE, taking off q whole 400-year cycles (up to 7), y remaining years
// (below 400) and m months (below 12), all through one shared compare and
// subtract unit; the weekday residue is registered in dccd_wkday meanwhile.
// busy falls in the result strobe cycle, so the next command can be taken at
// the edge that ends it; reset leaves the block idle with nothing to clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "day_count_to_calendar_date_macros.svh"

module day_count_to_calendar_date #(
	parameter int DAY_BITS = dccd_pkg::DAY_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [dccd_pkg::DAY_W-1:0]    day_offset,
	output logic                               busy,
	output logic                               done,
	output logic [dccd_pkg::YEAR_W-1:0]        year,
	output logic [dccd_pkg::MONTH_W-1:0]       month_number,
	output logic [dccd_pkg::MDAY_W-1:0]        day_of_month,
	output logic [dccd_pkg::WDAY_W-1:0]        weekday
);

	localparam int UsedBits = (DAY_BITS < dccd_pkg::DAY_W) ? DAY_BITS : dccd_pkg::DAY_W;
	localparam int RemW     = (UsedBits > dccd_pkg::CYCLE_BITS) ? UsedBits
		: dccd_pkg::CYCLE_BITS;

	dccd_pkg::state_t                  state_q, state_d;
	logic [RemW-1:0]                   rem_q, rem_d;
	logic [dccd_pkg::YEAR_W-1:0]       year_q, year_d;
	logic [dccd_pkg::YOFF_W-1:0]       yoff_q, yoff_d;
	logic [dccd_pkg::MONTH_W-1:0]      mon_q, mon_d;
	logic                              done_q, done_d;
	logic [RemW-1:0]                   operand;
	logic [RemW-1:0]                   diff;
	logic                              ge;
	logic                              leap;
	logic                              accept;
	dccd_pkg::wk_stat_t                wk;

	logic [dccd_pkg::YEAR_W-1:0]       year_q_o;
	logic [dccd_pkg::MONTH_W-1:0]      month_q_o;
	logic [dccd_pkg::MDAY_W-1:0]       mday_q_o;
	logic [dccd_pkg::WDAY_W-1:0]       wday_q_o;

	assign accept = start && !busy;
	assign leap   = dccd_pkg::leap_off(yoff_q);

	dccd_sub #(
		.W(RemW)
	) u_sub (
		.a   (rem_q),
		.b   (operand),
		.ge  (ge),
		.diff(diff)
	);

	dccd_wkday #(
		.NBITS(UsedBits)
	) u_wkday (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (accept),
		.value (day_offset[UsedBits-1:0]),
		.stat  (wk)
	);

	always_comb begin
		unique case (state_q)
			dccd_pkg::ST_CYCLE: operand = RemW'(dccd_pkg::CYCLE_DAYS);
			dccd_pkg::ST_YEAR:  operand = leap ? RemW'(dccd_pkg::DAYS_LEAP)
				: RemW'(dccd_pkg::DAYS_COMMON);
			dccd_pkg::ST_MONTH: operand = RemW'(dccd_pkg::month_len(mon_q, leap));
			default:            operand = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		year_d  = year_q;
		yoff_d  = yoff_q;
		mon_d   = mon_q;
		done_d  = 1'b0;
		unique case (state_q)
			dccd_pkg::ST_IDLE: begin
				if (accept) begin
					rem_d   = RemW'(day_offset[UsedBits-1:0]);
					year_d  = dccd_pkg::YEAR_W'(dccd_pkg::BASE_YEAR);
					yoff_d  = '0;
					mon_d   = '0;
					state_d = dccd_pkg::ST_CYCLE;
				end
			end
			dccd_pkg::ST_CYCLE: begin
				if (ge) begin
					rem_d  = diff;
					year_d = year_q + dccd_pkg::YEAR_W'(dccd_pkg::CYCLE_YEARS);
				end else begin
					state_d = dccd_pkg::ST_YEAR;
				end
			end
			dccd_pkg::ST_YEAR: begin
				if (ge) begin
					rem_d  = diff;
					year_d = year_q + 1'b1;
					yoff_d = yoff_q + 1'b1;
				end else begin
					state_d = dccd_pkg::ST_MONTH;
				end
			end
			dccd_pkg::ST_MONTH: begin
				if (ge && (mon_q != dccd_pkg::MONTH_DEC)) begin
					rem_d = diff;
					mon_d = mon_q + 1'b1;
				end else begin
					state_d = dccd_pkg::ST_DONE;
				end
			end
			dccd_pkg::ST_DONE: begin
				if (wk.idle) begin
					done_d  = 1'b1;
					state_d = dccd_pkg::ST_IDLE;
				end
			end
			default: state_d = dccd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dccd_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_d;
		year_q <= year_d;
		yoff_q <= yoff_d;
		mon_q  <= mon_d;
		if (done_d) begin
			year_q_o  <= year_q;
			month_q_o <= mon_q + 1'b1;
			mday_q_o  <= rem_q[dccd_pkg::MDAY_W-1:0] + 1'b1;
			wday_q_o  <= wk.residue;
		end
	end

	assign busy         = (state_q != dccd_pkg::ST_IDLE);
	assign done         = done_q;
	assign year         = year_q_o;
	assign month_number = month_q_o;
	assign day_of_month = mday_q_o;
	assign weekday      = wday_q_o;

	// checks
	`DCCD_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
	`DCCD_ASSERT_NEXT(a_start_busy, start && !busy, busy, "command transfer did not start work")
	`DCCD_ASSERT_NOW(a_month_range, done, (month_number != 4'd0) && (month_number <= 4'd12),
		"month out of range")
	`DCCD_ASSERT_NOW(a_wday_range, done, weekday != 3'd7, "weekday out of range")
	`DCCD_ASSERT_NOW(a_yoff_range, busy, yoff_q < 9'd400, "year offset left the cycle")

endmodule

`default_nettype wire

>>> dv/tb_day_count_to_calendar_date.sv
// ----------------------------------------------------------------------------
// tb_day_count_to_calendar_date
// self-checking bench for the day count to calendar date converter: a table
// of directed day offsets (epoch, month and year edges, non-leap centuries,
// 400-year cycle edges, top of range) is followed by random offsets biased
// towards year, february and cycle boundaries; results are checked against
// table dates or a behavioural date predictor; start is withheld at random
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_day_count_to_calendar_date;

	typedef struct packed {
		logic [dccd_pkg::YEAR_W-1:0]  yr;
		logic [dccd_pkg::MONTH_W-1:0] mon;
		logic [dccd_pkg::MDAY_W-1:0]  mday;
		logic [dccd_pkg::WDAY_W-1:0]  wday;
	} calendar_date_t;

	typedef struct packed {
		logic [dccd_pkg::DAY_W-1:0] offset;
		logic                       typed;
		calendar_date_t             want;
	} date_row_t;

	localparam int DATE_BITS   = $bits(calendar_date_t);
	localparam int NUM_ROWS    = 21;
	localparam int NUM_RANDOM  = 119;
	localparam int MAX_OFFSET  = (1 << dccd_pkg::DAY_W) - 1;
	localparam int DRAIN_CYCLES = 600;

	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31,
		30, 31};

	// offset, typed flag, expected date where it is obvious
	localparam date_row_t DATE_ROWS [NUM_ROWS] = '{
		{20'd0,       1'b1, 13'd2000, 4'd1,  5'd1,  3'd0},
		{20'd30,      1'b1, 13'd2000, 4'd1,  5'd31, 3'd2},
		{20'd31,      1'b1, 13'd2000, 4'd2,  5'd1,  3'd3},
		{20'd59,      1'b1, 13'd2000, 4'd2,  5'd29, 3'd3},
		{20'd60,      1'b1, 13'd2000, 4'd3,  5'd1,  3'd4},
		{20'd365,     1'b1, 13'd2000, 4'd12, 5'd31, 3'd1},
		{20'd366,     1'b1, 13'd2001, 4'd1,  5'd1,  3'd2},
		{20'd424,     1'b0, {DATE_BITS{1'b0}}},
		{20'd1461,    1'b0, {DATE_BITS{1'b0}}},
		{20'd1519,    1'b0, {DATE_BITS{1'b0}}},
		{20'd36524,   1'b0, {DATE_BITS{1'b0}}},
		{20'd36583,   1'b0, {DATE_BITS{1'b0}}},
		{20'd36584,   1'b0, {DATE_BITS{1'b0}}},
		{20'd146096,  1'b0, {DATE_BITS{1'b0}}},
		{20'd146097,  1'b0, {DATE_BITS{1'b0}}},
		{20'd146156,  1'b0, {DATE_BITS{1'b0}}},
		{20'd1022679, 1'b0, {DATE_BITS{1'b0}}},
		{20'h55555,   1'b0, {DATE_BITS{1'b0}}},
		{20'haaaaa,   1'b0, {DATE_BITS{1'b0}}},
		{20'hffffe,   1'b0, {DATE_BITS{1'b0}}},
		{20'hfffff,   1'b0, {DATE_BITS{1'b0}}}
	};

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          start      = 1'b0;
	logic [dccd_pkg::DAY_W-1:0]    day_offset = '0;
	logic                          busy;
	logic                          done;
	logic [dccd_pkg::YEAR_W-1:0]   year;
	logic [dccd_pkg::MONTH_W-1:0]  month_number;
	logic [dccd_pkg::MDAY_W-1:0]   day_of_month;
	logic [dccd_pkg::WDAY_W-1:0]   weekday;

	logic                use_typed  = 1'b0;
	calendar_date_t      typed_date = '0;

	calendar_date_t      pending_dates [$];
	calendar_date_t      oldest_date;
	int                  mismatches     = 0;
	int                  dates_checked  = 0;
	int                  offsets_sent   = 0;

	day_count_to_calendar_date dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.day_offset   (day_offset),
		.busy         (busy),
		.done         (done),
		.year         (year),
		.month_number (month_number),
		.day_of_month (day_of_month),
		.weekday      (weekday)
	);

	always #4 clk = ~clk;

	function automatic bit is_leap_year(input int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic calendar_date_t date_of_offset(
		input logic [dccd_pkg::DAY_W-1:0] offset);
		calendar_date_t d;
		int unsigned    rest;
		int unsigned    yr;
		int unsigned    len;
		int             mo;
		rest = offset;
		yr   = dccd_pkg::BASE_YEAR
			+ dccd_pkg::CYCLE_YEARS * (rest / dccd_pkg::CYCLE_DAYS);
		rest = rest % dccd_pkg::CYCLE_DAYS;
		while (rest >= (is_leap_year(yr) ? dccd_pkg::DAYS_LEAP : dccd_pkg::DAYS_COMMON))
		begin
			rest -= is_leap_year(yr) ? dccd_pkg::DAYS_LEAP : dccd_pkg::DAYS_COMMON;
			yr++;
		end
		for (mo = 0; mo < 11; mo++) begin
			len = MONTH_DAYS[mo]
				+ ((mo == dccd_pkg::MONTH_FEB && is_leap_year(yr)) ? 1 : 0);
			if (rest < len)
				break;
			rest -= len;
		end
		d.yr   = yr[dccd_pkg::YEAR_W-1:0];
		d.mon  = dccd_pkg::MONTH_W'(mo + 1);
		d.mday = dccd_pkg::MDAY_W'(rest + 1);
		d.wday = dccd_pkg::WDAY_W'(offset % dccd_pkg::WEEK_DAYS);
		return d;
	endfunction

	// first day of a given year, as a day offset
	function automatic int unsigned year_start(input int unsigned y);
		int unsigned p;
		p = y - 1;
		return (y - dccd_pkg::BASE_YEAR) * dccd_pkg::DAYS_COMMON
			+ (p / 4 - p / 100 + p / 400) - (1999 / 4 - 1999 / 100 + 1999 / 400);
	endfunction

	task automatic send_offset(input logic [dccd_pkg::DAY_W-1:0] offset,
		input logic typed, input calendar_date_t want);
		start      <= 1'b1;
		day_offset <= offset;
		use_typed  <= typed;
		typed_date <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		offsets_sent++;
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic int pick_gap(input bit no_idle);
		if (no_idle)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 80);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(1, 4);
	endfunction

	// result checking and expectation store
	always @(posedge clk) begin
		if (done) begin
			if (pending_dates.size() == 0) begin
				$error("result strobe with no date outstanding");
				mismatches++;
			end else begin
				oldest_date = pending_dates.pop_front();
				dates_checked++;
				if (year !== oldest_date.yr) begin
					$error("year: expected %0d, got %0d", oldest_date.yr, year);
					mismatches++;
				end
				if (month_number !== oldest_date.mon) begin
					$error("month_number: expected %0d, got %0d", oldest_date.mon,
						month_number);
					mismatches++;
				end
				if (day_of_month !== oldest_date.mday) begin
					$error("day_of_month: expected %0d, got %0d", oldest_date.mday,
						day_of_month);
					mismatches++;
				end
				if (weekday !== oldest_date.wday) begin
					$error("weekday: expected %0d, got %0d", oldest_date.wday, weekday);
					mismatches++;
				end
			end
		end
		if (arst_n && start && !busy)
			pending_dates.push_back(use_typed ? typed_date : date_of_offset(day_offset));
	end

	initial begin
		int          i;
		int          k;
		int          pick;
		bit          no_idle;
		int unsigned offset;
		int unsigned y;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NUM_ROWS; i++) begin
			send_offset(DATE_ROWS[i].offset, DATE_ROWS[i].typed, DATE_ROWS[i].want);
			hold_off(pick_gap(i < 6));
		end

		no_idle = 1'b0;
		for (i = 0; i < NUM_RANDOM; i++) begin
			if (i % 12 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 3);
			case (pick)
				0: offset = $urandom & MAX_OFFSET;
				1: offset = $urandom_range(0, 3000);
				2: begin
					// around a 400-year cycle edge
					k = $urandom_range(0, 7);
					offset = k * dccd_pkg::CYCLE_DAYS + $urandom_range(0, 800);
					offset = (offset >= 400 && k > 0) ? offset - 400 : offset;
				end
				default: begin
					// around new year or the end of february
					y = $urandom_range(dccd_pkg::BASE_YEAR, 4870);
					offset = year_start(y) + ($urandom_range(0, 1) ? 57 : 0)
						+ $urandom_range(0, 3);
					offset = (offset > 0 && $urandom_range(0, 3) == 0) ? offset - 1 : offset;
				end
			endcase
			if (offset > MAX_OFFSET)
				offset = MAX_OFFSET;
			send_offset(dccd_pkg::DAY_W'(offset), 1'b0, '0);
			hold_off(pick_gap(no_idle));
		end
		start <= 1'b0;

		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d day offsets sent (%0d from the table), %0d dates compared",
			offsets_sent, NUM_ROWS, dates_checked);
		$display("covered leap and century years, 400-year cycle edges and the top offset");
		if (mismatches == 0 && pending_dates.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule
